### design/stereo_amplitude_histogram_core_macros.svh
// assertion helpers shared by the histogram core
`ifndef STEREO_AMPLITUDE_HISTOGRAM_CORE_MACROS_SVH
`define STEREO_AMPLITUDE_HISTOGRAM_CORE_MACROS_SVH

// same-cycle implication
`define SAH_ASSERT_IMP(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SAH_ASSERT_NXT(label, clk, dis, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/sah_pkg.sv
package sah_pkg;

   // histogram geometry
   localparam int SAMPLE_BITS = 16;
   localparam int BIN_SHIFT   = 8;
   localparam int BIN_BITS    = SAMPLE_BITS - BIN_SHIFT;
   localparam int NBINS       = 1 << BIN_BITS;
   localparam int NHIST       = 4;
   localparam int HIST_BITS   = 2;
   localparam int COUNT_BITS  = 32;
   localparam int OUT_BITS    = 32;
   localparam int INDEX_BITS  = 8;

   // item queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // register file
   localparam int CSR_ADDR_BITS = 3;
   localparam logic REG_STEREO_MODE = 1'b0;

   // input opcodes
   localparam logic [1:0] OPC_COUNT = 2'd0;
   localparam logic [1:0] OPC_READ  = 2'd1;
   localparam logic [1:0] OPC_CLEAR = 2'd2;

   // histogram numbers
   localparam int HIST_LEFT  = 0;
   localparam int HIST_RIGHT = 1;
   localparam int HIST_MID   = 2;
   localparam int HIST_SIDE  = 3;

   typedef enum logic [1:0] {
      KIND_COUNT,
      KIND_READ,
      KIND_CLEAR
   } kind_type;

   // classified item as it waits in the queue
   typedef struct packed {
      kind_type                            kind;
      logic [NHIST-1:0]                    hist_en;
      logic [NHIST-1:0][BIN_BITS-1:0]      bin;
      logic [HIST_BITS-1:0]                sel;
      logic                                oor;
   } sah_item_type;

   // back end activity seen by the top level
   typedef struct packed {
      logic clearing;
      logic updating;
      logic reading;
      logic taking;
   } sah_status_type;

   // offset binary sample, top bits form the bin
   function automatic logic [BIN_BITS-1:0] bin_of(input logic signed [SAMPLE_BITS-1:0] v);
      logic [SAMPLE_BITS-1:0] off;
      off = {~v[SAMPLE_BITS-1], v[SAMPLE_BITS-2:0]};
      return off[SAMPLE_BITS-1 -: BIN_BITS];
   endfunction

   // halve a 17-bit sum, rounding toward zero
   function automatic logic signed [SAMPLE_BITS-1:0] half_tz(
      input logic signed [SAMPLE_BITS:0] s);
      logic signed [SAMPLE_BITS:0] adj;
      adj = s + (SAMPLE_BITS+1)'(s[SAMPLE_BITS]);
      return adj[SAMPLE_BITS:1];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
   endfunction

   // saturate a counter into the 32-bit result field
   function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return (w > 64'h0000_0000_FFFF_FFFF) ? {OUT_BITS{1'b1}} : w[OUT_BITS-1:0];
   endfunction

endpackage

### design/sah_front.sv
module sah_front
   import sah_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          stereo_mode,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic [HIST_BITS-1:0]          req_hist_select,
   input  logic [INDEX_BITS-1:0]         req_bin_index,
   output logic                          item_valid,
   output sah_item_type                  item,
   input  logic                          item_take
);

   sah_item_type                  new_item;
   logic                          new_ok;
   logic signed [SAMPLE_BITS-1:0] mid;
   logic signed [SAMPLE_BITS-1:0] side;
   logic [31:0]                   index_wide;
   logic                          push;

   sah_item_type                  entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]          wr_ptr_ff;
   logic [QPTR_BITS-1:0]          rd_ptr_ff;
   logic [QPTR_BITS:0]            count_ff;

   // classify the incoming item and work out its bins
   always_comb begin
      mid = half_tz((SAMPLE_BITS+1)'(req_left_sample) + (SAMPLE_BITS+1)'(req_right_sample));
      side = half_tz((SAMPLE_BITS+1)'(req_left_sample) - (SAMPLE_BITS+1)'(req_right_sample));
      index_wide = 32'(req_bin_index);
      new_item = '0;
      new_ok = 1'b1;
      new_item.sel = req_hist_select;
      case (req_opcode)
         OPC_COUNT: begin
            new_item.kind = KIND_COUNT;
            new_item.hist_en = {{(NHIST-1){stereo_mode}}, 1'b1};
            new_item.bin[HIST_LEFT] = bin_of(req_left_sample);
            new_item.bin[HIST_RIGHT] = bin_of(req_right_sample);
            new_item.bin[HIST_MID] = bin_of(mid);
            new_item.bin[HIST_SIDE] = bin_of(side);
         end
         OPC_READ: begin
            new_item.kind = KIND_READ;
            new_item.oor = (index_wide >= 32'(NBINS));
            for (int h = 0; h < NHIST; h++) begin
               new_item.bin[h] = index_wide[BIN_BITS-1:0];
            end
         end
         OPC_CLEAR: begin
            new_item.kind = KIND_CLEAR;
         end
         default: begin
            new_item.kind = KIND_COUNT;
            new_ok = 1'b0;
         end
      endcase
   end

   // unused opcodes are taken and dropped
   assign req_ready = (count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign push = req_valid && req_ready && new_ok;
   assign item_valid = (count_ff != '0);
   assign item = entries_ff[rd_ptr_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (item_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !item_take) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && item_take) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### design/sah_back.sv
module sah_back
   import sah_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  sah_item_type          item,
   output logic                  item_take,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [OUT_BITS-1:0]   rsp_bin_count,
   output logic [OUT_BITS-1:0]   rsp_frames_total,
   output sah_status_type        status
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_READ
   } state_type;

   state_type             state_ff;
   logic [BIN_BITS-1:0]   clear_ptr_ff;
   logic [COUNT_BITS-1:0] frames_ff;
   sah_item_type          cur_ff;
   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   bin_count_ff;
   logic [OUT_BITS-1:0]   frames_total_ff;

   logic [COUNT_BITS-1:0] rd_data_ff [NHIST];
   logic [NHIST-1:0]      wr_en;
   logic [BIN_BITS-1:0]   wr_addr [NHIST];
   logic [COUNT_BITS-1:0] wr_data [NHIST];
   logic                  load;
   logic [OUT_BITS-1:0]   sel_count;

   assign item_take = (state_ff == ST_IDLE) && item_valid;
   assign load = (state_ff == ST_READ) && (!rsp_valid_ff || rsp_ready);
   assign sel_count = cur_ff.oor ? '0 : clip_out(rd_data_ff[cur_ff.sel]);

   // write port: zero sweep or saturating increment
   always_comb begin
      for (int h = 0; h < NHIST; h++) begin
         wr_addr[h] = cur_ff.bin[h];
         wr_data[h] = sat_inc(rd_data_ff[h]);
      end
      wr_en = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = '1;
            for (int h = 0; h < NHIST; h++) begin
               wr_addr[h] = clear_ptr_ff;
               wr_data[h] = '0;
            end
         end
         ST_UPDATE: begin
            wr_en = cur_ff.hist_en;
         end
         default: begin
            wr_en = '0;
         end
      endcase
   end

   // one bin memory per histogram
   for (genvar g = 0; g < NHIST; g++) begin : g_hist
      logic [COUNT_BITS-1:0] mem [NBINS];

      always_ff @(posedge clock) begin
         if (wr_en[g]) begin
            mem[wr_addr[g]] <= wr_data[g];
         end
         if (item_take) begin
            rd_data_ff[g] <= mem[item.bin[g]];
         end
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ptr_ff <= '0;
         frames_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clear_ptr_ff <= clear_ptr_ff + 1'b1;
               if (clear_ptr_ff == BIN_BITS'(NBINS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (item_take) begin
                  cur_ff <= item;
                  case (item.kind)
                     KIND_COUNT: state_ff <= ST_UPDATE;
                     KIND_READ:  state_ff <= ST_READ;
                     default: begin
                        state_ff <= ST_CLEAR;
                        clear_ptr_ff <= '0;
                        frames_ff <= '0;
                     end
                  endcase
               end
            end
            ST_UPDATE: begin
               frames_ff <= sat_inc(frames_ff);
               state_ff <= ST_IDLE;
            end
            ST_READ: begin
               if (load) begin
                  rsp_valid_ff <= 1'b1;
                  bin_count_ff <= sel_count;
                  frames_total_ff <= clip_out(frames_ff);
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_bin_count = bin_count_ff;
   assign rsp_frames_total = frames_total_ff;

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.updating = (state_ff == ST_UPDATE);
   assign status.reading = (state_ff == ST_READ);
   assign status.taking = item_take;

endmodule

### design/stereo_amplitude_histogram_core.sv
// Stereo amplitude histogram: left, right, mid and side bin counters.
// Request channel (req_*, valid/ready) carries one item per transfer:
//   count a frame, read one bin, or clear all histograms. Unused opcodes
//   are taken and dropped. Only a read gives a response on rsp_*, which
//   carries the bin count and the frame total, both saturated to 32 bits.
// A two-entry queue lets the request side keep accepting while the
// counter side works. Each count or read holds the counter side for a
// memory read and then a write-back or result load, so it takes no new
// item until the last is done; this read-modify-write on the single-port
// bin memories sets the sustained rate.
// With the queue empty, a read passes the queue entry, the memory read
// register and the output register before its response is valid. A clear
// zeroes the frame total at once and then sweeps the memories one bin per
// cycle over all 256 bins, with all four histograms written in parallel.
// After reset the same sweep runs; the queue still takes up to two items
// meanwhile. The stereo_mode register resets to 1.
// When the receiver stalls the response is held in its output register; the
// counter side waits on the next read, and requests back up through the
// queue to req_ready.
`include "stereo_amplitude_histogram_core_macros.svh"

module stereo_amplitude_histogram_core
   import sah_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic [HIST_BITS-1:0]          req_hist_select,
   input  logic [INDEX_BITS-1:0]         req_bin_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [OUT_BITS-1:0]           rsp_bin_count,
   output logic [OUT_BITS-1:0]           rsp_frames_total,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic           stereo_mode_ff;
   logic           item_valid;
   sah_item_type   item;
   logic           item_take;
   sah_status_type back_status;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_STEREO_MODE) ? {31'b0, stereo_mode_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_mode_ff <= 1'b1;
      end else if (psel && penable && pwrite && pready && (paddr[2] == REG_STEREO_MODE)) begin
         stereo_mode_ff <= pwdata[0];
      end
   end

   sah_front u_front (
      .clock            (clock),
      .reset            (reset),
      .stereo_mode      (stereo_mode_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_hist_select  (req_hist_select),
      .req_bin_index    (req_bin_index),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   sah_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_bin_count    (rsp_bin_count),
      .rsp_frames_total (rsp_frames_total),
      .status           (back_status)
   );

   // reset always starts the zero sweep
   `SAH_ASSERT_NXT(a_reset_sweep, clock, 1'b0, reset, back_status.clearing, "no sweep after reset")
   // nothing leaves the queue while the sweep runs
   `SAH_ASSERT_IMP(a_no_take_in_sweep, clock, reset, back_status.clearing, !back_status.taking, "item taken during sweep")
   // a new response only comes out of a read
   `SAH_ASSERT_IMP(a_rsp_from_read, clock, reset, $rose(rsp_valid), $past(back_status.reading), "response without read")

endmodule
